// ----- hw/rtl/chrl_pkg.sv -----
// Package for the consistent-hash ring lookup block.
// Holds field widths, opcode and status codes, and the controller/datapath structs.
// No dependencies.
package chrl_pkg;

    localparam int RING_ENTRIES_DEF = 128;

    localparam int POS_W    = 32;
    localparam int OWNER_W  = 6;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // item accepted: capture it, clear the scan
        logic rd;      // issue one table read, advance the scan index
        logic commit;  // store an add, load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_req;    // accepted item is a lookup on a non-empty ring
        logic last_issue;  // current read is of the last stored entry
    } sts_t;

endpackage

// ----- hw/rtl/chrl_if.sv -----
// Valid/ready channel interfaces for the ring lookup block.
// Depends on chrl_pkg for field widths.
interface chrl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [chrl_pkg::POS_W-1:0]   ring_position;
    logic [chrl_pkg::OWNER_W-1:0] owner_node;

    modport source (output valid, output opcode, output ring_position, output owner_node,
                    input ready);
    modport sink   (input valid, input opcode, input ring_position, input owner_node,
                    output ready);
endinterface

interface chrl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [chrl_pkg::STATUS_W-1:0] status;
    logic [chrl_pkg::OWNER_W-1:0]  found_node;
    logic [chrl_pkg::ID_W-1:0]     entry_id;

    modport source (output valid, output status, output found_node, output entry_id,
                    input ready);
    modport sink   (input valid, input status, input found_node, input entry_id,
                    output ready);
endinterface

// ----- hw/rtl/chrl_ctrl.sv -----
// Controller state machine for the ring lookup block.
// Depends on chrl_pkg for the command and status structs.
module chrl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  chrl_pkg::sts_t  sts,
    output chrl_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd.start  = accept;
        cmd.rd     = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_DONE) && (!out_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.scan_req ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (sts.last_issue)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd.commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result appears only out of the commit state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside commit");

    // commit always leaves a result waiting
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && state_reg == S_IDLE)
        else $error("commit lost its result");

endmodule

// ----- hw/rtl/chrl_dp.sv -----
// Datapath for the ring lookup block: entry table, scan accumulators, result register.
// Depends on chrl_pkg for widths, codes and the command and status structs.
module chrl_dp #(
    parameter int RING_ENTRIES = chrl_pkg::RING_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_opcode,
    input  logic [chrl_pkg::POS_W-1:0]   in_position,
    input  logic [chrl_pkg::OWNER_W-1:0] in_owner,
    input  chrl_pkg::cmd_t               cmd,
    output chrl_pkg::sts_t               sts,
    output logic [chrl_pkg::STATUS_W-1:0] out_status,
    output logic [chrl_pkg::OWNER_W-1:0] out_node,
    output logic [chrl_pkg::ID_W-1:0]    out_id
);

    localparam int CNT_W  = $clog2(RING_ENTRIES + 1);
    localparam int IDX_W  = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int WORD_W = chrl_pkg::POS_W + chrl_pkg::OWNER_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RING_ENTRIES);

    logic [WORD_W-1:0] ring_mem [RING_ENTRIES];

    logic                         op_reg;
    logic [chrl_pkg::POS_W-1:0]   key_reg;
    logic [chrl_pkg::OWNER_W-1:0] owner_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         rd_valid_reg;
    logic [chrl_pkg::POS_W-1:0]   rd_pos_reg;
    logic [chrl_pkg::OWNER_W-1:0] rd_owner_reg;
    logic                         first_reg;
    logic                         have_succ_reg;
    logic [chrl_pkg::POS_W-1:0]   succ_pos_reg;
    logic [chrl_pkg::OWNER_W-1:0] succ_owner_reg;
    logic [chrl_pkg::POS_W-1:0]   min_pos_reg;
    logic [chrl_pkg::OWNER_W-1:0] min_owner_reg;
    chrl_pkg::status_t            status_reg;
    logic [chrl_pkg::OWNER_W-1:0] node_reg;
    logic [chrl_pkg::ID_W-1:0]    id_reg;

    logic             is_full;
    logic             do_write;
    logic [CNT_W-1:0] count_inc;
    logic             take_min;
    logic             take_succ;

    assign is_full   = (count_reg >= FULL_COUNT);
    assign do_write  = cmd.commit && (op_reg == chrl_pkg::OP_ADD) && !is_full;
    assign count_inc = count_reg + CNT_W'(1);

    assign sts.scan_req   = (in_opcode == chrl_pkg::OP_LOOKUP) && (count_reg != '0);
    assign sts.last_issue = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    // earliest entry wins a tie: replace only on strictly smaller
    assign take_min  = rd_valid_reg && (first_reg || rd_pos_reg < min_pos_reg);
    assign take_succ = rd_valid_reg && (rd_pos_reg >= key_reg)
                       && (!have_succ_reg || rd_pos_reg < succ_pos_reg);

    // entry table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ring_mem[count_reg[IDX_W-1:0]] <= {key_reg, owner_reg};
        end
        if (cmd.rd)
        begin
            {rd_pos_reg, rd_owner_reg} <= ring_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd;
            if (do_write)
            begin
                count_reg <= count_inc;
            end
        end
    end

    // capture, scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg        <= in_opcode;
            key_reg       <= in_position;
            owner_reg     <= in_owner;
            idx_reg       <= '0;
            first_reg     <= 1'b1;
            have_succ_reg <= 1'b0;
        end
        else if (cmd.rd)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (rd_valid_reg)
        begin
            first_reg <= 1'b0;
        end
        if (take_min)
        begin
            min_pos_reg   <= rd_pos_reg;
            min_owner_reg <= rd_owner_reg;
        end
        if (take_succ)
        begin
            have_succ_reg  <= 1'b1;
            succ_pos_reg   <= rd_pos_reg;
            succ_owner_reg <= rd_owner_reg;
        end
        if (cmd.commit)
        begin
            node_reg <= '0;
            id_reg   <= '0;
            if (op_reg == chrl_pkg::OP_ADD)
            begin
                if (is_full)
                begin
                    status_reg <= chrl_pkg::ST_FULL;
                end
                else
                begin
                    status_reg <= chrl_pkg::ST_OK;
                    id_reg     <= chrl_pkg::ID_W'(count_inc);
                end
            end
            else if (count_reg == '0)
            begin
                status_reg <= chrl_pkg::ST_EMPTY;
            end
            else
            begin
                status_reg <= chrl_pkg::ST_OK;
                node_reg   <= have_succ_reg ? succ_owner_reg : min_owner_reg;
            end
        end
    end

    assign out_status = status_reg;
    assign out_node   = node_reg;
    assign out_id     = id_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> count_reg == $past(count_inc))
        else $error("add did not advance the count");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> CNT_W'(idx_reg) < count_reg)
        else $error("scan read beyond stored entries");

endmodule

// ----- hw/rtl/consistent_hash_ring_lookup.sv -----
// Consistent-hash ring successor lookup, top level.
// Depends on chrl_pkg, chrl_if (chrl_req_if, chrl_rsp_if), chrl_ctrl and chrl_dp.
//
// The block holds a table of up to RING_ENTRIES virtual-node entries, each a 32-bit ring
// position and a 6-bit owner id, kept in one single-port-write, single-port-read memory.
// An add item (opcode 0) appends an entry and returns the new entry count as entry_id
// (masked to 8 bits), or status full with zeroed fields when the table is full. A
// lookup item (opcode 1) reads the stored entries one per cycle through the memory
// read port and, in the same pass, keeps the smallest position at or above the hash
// and the overall smallest position; the owner of the first, or of the second when
// nothing lies at or above the hash, is returned, with ties going to the earliest
// entry. An empty ring answers with status empty without a scan. Owner ids are
// stored and returned without any range check. One item is in flight at a time; the
// next item is taken the cycle after the result is loaded, even while that result
// still waits on the output register. The table needs no clearing after reset: only
// entries below the count are ever read.
module consistent_hash_ring_lookup #(
    parameter int RING_ENTRIES = chrl_pkg::RING_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    chrl_req_if.sink    req,
    chrl_rsp_if.source  rsp
);

    chrl_pkg::cmd_t cmd;
    chrl_pkg::sts_t sts;

    // sequencing: accept, scan, drain the last read, commit
    chrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table, compare-and-keep scan and result register
    chrl_dp #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_opcode   (req.opcode),
        .in_position (req.ring_position),
        .in_owner    (req.owner_node),
        .cmd         (cmd),
        .sts         (sts),
        .out_status  (rsp.status),
        .out_node    (rsp.found_node),
        .out_id      (rsp.entry_id)
    );

endmodule
